@@ rtl/icsc_pkg.sv @@
// shared constants, types and character functions for the identifier case-style converter
// depends on nothing; imported by icsc_scan, the top level, the checker and the testbench
package icsc_pkg;

  localparam int MAX_LEN = 32;
  localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);

  localparam logic [7:0] CH_US = 8'h5F;  // underscore
  localparam logic [7:0] CH_DS = 8'h2D;  // dash

  typedef logic [2:0] style_t;
  localparam style_t STY_CAMEL        = 3'd0;
  localparam style_t STY_PASCAL       = 3'd1;
  localparam style_t STY_SNAKE        = 3'd2;
  localparam style_t STY_UPPER_SNAKE  = 3'd3;
  localparam style_t STY_SCREAM_SNAKE = 3'd4;
  localparam style_t STY_KEBAB        = 3'd5;
  localparam style_t STY_UPPER_KEBAB  = 3'd6;
  localparam style_t STY_SCREAM_KEBAB = 3'd7;

  // what the load-time scan learned about the stored identifier
  typedef struct packed {
    logic [LEN_W-1:0]   core_b;   // first index of the core
    logic [LEN_W-1:0]   core_e;   // one past the last index of the core
    logic               has_us;   // core holds an underscore
    logic               has_ds;   // core holds a dash
    logic [MAX_LEN-1:0] bnd;      // camel split: a component starts here
  } scan_info_t;

  function automatic logic is_up(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_lo(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7A);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_US) || (c == CH_DS);
  endfunction

  // separator placed between components by the snake and kebab styles
  function automatic logic [7:0] style_sep(input style_t st);
    return (st >= STY_KEBAB) ? CH_DS : CH_US;
  endfunction

  function automatic logic needs_sep(input style_t st);
    return st >= STY_SNAKE;
  endfunction

  // case mapping of one component letter
  function automatic logic [7:0] map_char(input logic [7:0] c, input style_t st,
                                          input logic first, input logic nz);
    logic u;
    begin
      if ((st == STY_SCREAM_SNAKE) || (st == STY_SCREAM_KEBAB)) u = 1'b1;
      else if (!first) u = 1'b0;
      else if (st == STY_CAMEL) u = nz;
      else u = (st == STY_PASCAL) || (st == STY_UPPER_SNAKE) || (st == STY_UPPER_KEBAB);
      if (u && is_lo(c)) return c - 8'd32;
      else if (!u && is_up(c)) return c + 8'd32;
      else return c;
    end
  endfunction

endpackage

@@ rtl/icsc_ram.sv @@
// generic single write port, single read port ram with registered read
// no dependencies
module icsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [$clog2(DEPTH)-1:0]       waddr,
  input  logic [WIDTH-1:0]               wdata,
  input  logic [$clog2(DEPTH)-1:0]       raddr,
  output logic [WIDTH-1:0]               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/icsc_scan.sv @@
// load-time scan: finds the core bounds, the split separator and camel boundaries
// depends on icsc_pkg
module icsc_scan (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic                      wr,
  input  logic [7:0]                ch,
  input  logic [icsc_pkg::IDX_W-1:0] idx,
  output icsc_pkg::scan_info_t      info
);
  import icsc_pkg::*;

  typedef enum logic [1:0] {M_START, M_LOW, M_UP} mode_t;

  mode_t              mode;
  logic               seen_ns;
  logic               first_nonup;
  logic               at_start;
  logic               pend_us;
  logic               pend_ds;
  logic               has_us;
  logic               has_ds;
  logic [LEN_W-1:0]   b;
  logic [LEN_W-1:0]   e;
  logic [MAX_LEN-1:0] bnd;
  logic [LEN_W-1:0]   idx_p1;

  assign idx_p1 = LEN_W'(idx) + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      mode        <= M_START;
      seen_ns     <= 1'b0;
      first_nonup <= 1'b0;
      at_start    <= 1'b0;
      pend_us     <= 1'b0;
      pend_ds     <= 1'b0;
      has_us      <= 1'b0;
      has_ds      <= 1'b0;
      b           <= '0;
      e           <= '0;
      bnd         <= '0;
    end else if (wr) begin
      if (!seen_ns) begin
        if (is_sep(ch)) begin
          b <= idx_p1;
        end else begin
          seen_ns     <= 1'b1;
          e           <= idx_p1;
          first_nonup <= !is_up(ch);
          at_start    <= 1'b1;
          mode        <= M_START;
        end
      end else begin
        if (!is_sep(ch)) begin
          e <= idx_p1;
          if (pend_us) has_us <= 1'b1;
          if (pend_ds) has_ds <= 1'b1;
        end
        if (ch == CH_US) pend_us <= 1'b1;
        if (ch == CH_DS) pend_ds <= 1'b1;
        at_start <= 1'b0;
        unique case (mode)
          M_START: begin
            if (!is_up(ch)) mode <= M_LOW;
            else if (at_start && first_nonup) bnd[idx] <= 1'b1;
            else mode <= M_UP;
          end
          M_LOW: begin
            if (is_up(ch)) begin
              bnd[idx] <= 1'b1;
              mode     <= M_START;
            end
          end
          M_UP: begin
            // the last capital of a run opens the next word
            if (is_lo(ch)) begin
              bnd[IDX_W'(idx - 1'b1)] <= 1'b1;
              mode <= M_LOW;
            end
          end
          default: mode <= M_START;
        endcase
      end
    end
  end

  assign info.core_b = b;
  assign info.core_e = seen_ns ? e : b;
  assign info.has_us = has_us;
  assign info.has_ds = has_ds;
  assign info.bnd    = bnd;

endmodule

@@ rtl/identifier_case_style_converter.sv @@
// top level of the identifier case-style converter: load, sequencer and output register
// depends on icsc_pkg, icsc_ram and icsc_scan
//
// Identifier characters arrive one per transfer on the s_ side, s_tlast on the last one,
// and are taken one per cycle, unless the output register is stalled, into a MAX_LEN
// byte store, while a scan notes the leading and trailing separator runs, which separator
// splits the core and where camel words begin. The last character starts the conversion:
// the sequencer walks the store, reading each byte in a fetch state (the store's read
// port is registered) and then mapping it in a char state, and in the snake and kebab
// styles it first inserts a separator at each camel word boundary; no character is
// taken until the last byte has been handled. An identifier longer than MAX_LEN gives
// one transfer with too_long set and out_char zero. target_style is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, as the block
// itself does not enforce this.
module identifier_case_style_converter (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,   // target_style
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,     // character
  input  logic       s_tlast,     // final_char
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,     // out_char
  output logic       m_tlast,     // end_of_output
  output logic       m_tuser      // too_long
);
  import icsc_pkg::*;

  typedef enum logic [1:0] {S_LOAD, S_FETCH, S_CHAR} state_t;

  state_t           state;
  style_t           style;
  logic [LEN_W-1:0] count;      // bytes stored so far
  logic             overflow;
  logic [LEN_W-1:0] len;        // bytes to convert
  logic [LEN_W-1:0] pos;        // read position during emission
  logic             comp_first; // next core byte opens a component
  logic             comp_nz;    // a component has already ended
  logic             sep_done;   // word separator already sent for this byte

  scan_info_t       info;
  logic [7:0]       rd_data;
  logic             out_free;
  logic             out_load;
  logic             s_xfer;
  logic             store_wr;
  logic             scan_clear;

  // per-byte decode during emission
  logic             in_core;
  logic             split_sep;
  logic [7:0]       split_ch;
  logic             is_split;
  logic             first;
  logic             nz;
  logic             need_pre;
  logic [7:0]       mapped;
  logic [LEN_W-1:0] pos_next;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_LOAD) && out_free;
  assign s_xfer   = s_tvalid && s_tready;
  assign store_wr = s_xfer && (count < LEN_W'(MAX_LEN));

  always_ff @(posedge clk) begin
    if (rst) begin
      style <= STY_CAMEL;
    end else if (cfg_we) begin
      style <= cfg_wdata;
    end
  end

  icsc_ram #(
    .WIDTH(8),
    .DEPTH(MAX_LEN)
  ) u_store (
    .clk  (clk),
    .we   (store_wr),
    .waddr(count[IDX_W-1:0]),
    .wdata(s_tdata),
    .raddr(pos[IDX_W-1:0]),
    .rdata(rd_data)
  );

  icsc_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .clear(scan_clear),
    .wr   (store_wr),
    .ch   (s_tdata),
    .idx  (count[IDX_W-1:0]),
    .info (info)
  );

  // split on underscore first, then dash, else at camel boundaries
  assign in_core   = (pos >= info.core_b) && (pos < info.core_e);
  assign split_sep = info.has_us || info.has_ds;
  assign split_ch  = info.has_us ? CH_US : CH_DS;
  assign is_split  = in_core && split_sep && (rd_data == split_ch);
  assign first     = split_sep ? comp_first
                               : ((pos == info.core_b) || info.bnd[pos[IDX_W-1:0]]);
  assign nz        = split_sep ? comp_nz : (pos != info.core_b);
  assign need_pre  = in_core && !split_sep && info.bnd[pos[IDX_W-1:0]]
                     && needs_sep(style) && !sep_done;
  assign mapped    = in_core ? map_char(rd_data, style, first, nz) : rd_data;
  assign pos_next  = pos + LEN_W'(1);

  // output register takes a new byte: flagged result, inserted separator, converted input separator or mapped byte
  assign out_load = (s_xfer && s_tlast && !store_wr)
                    || ((state == S_CHAR) && out_free
                        && (need_pre || !is_split || needs_sep(style)));

  assign scan_clear = ((state == S_CHAR) && out_free && !need_pre && (pos_next == len))
                      || (s_xfer && s_tlast && (overflow || (count == LEN_W'(MAX_LEN))));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      count      <= '0;
      overflow   <= 1'b0;
      len        <= '0;
      pos        <= '0;
      comp_first <= 1'b0;
      comp_nz    <= 1'b0;
      sep_done   <= 1'b0;
      m_tvalid   <= 1'b0;
      m_tdata    <= '0;
      m_tlast    <= 1'b0;
      m_tuser    <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_LOAD: begin
          if (s_xfer) begin
            if (store_wr) count <= count + LEN_W'(1);
            else if (!s_tlast) overflow <= 1'b1;
            if (s_tlast) begin
              if (!store_wr) begin
                // too long: single flagged transfer
                m_tdata  <= '0;
                m_tlast  <= 1'b1;
                m_tuser  <= 1'b1;
                count    <= '0;
                overflow <= 1'b0;
              end else begin
                len        <= count + LEN_W'(1);
                pos        <= '0;
                comp_first <= 1'b1;
                comp_nz    <= 1'b0;
                sep_done   <= 1'b0;
                state      <= S_FETCH;
              end
            end
          end
        end
        S_FETCH: begin
          state <= S_CHAR;
        end
        S_CHAR: begin
          if (out_free) begin
            if (need_pre) begin
              m_tdata  <= style_sep(style);
              m_tlast  <= 1'b0;
              m_tuser  <= 1'b0;
              sep_done <= 1'b1;
            end else begin
              if (is_split) begin
                // separator in the input becomes the style's separator or vanishes
                if (needs_sep(style)) begin
                  m_tdata  <= style_sep(style);
                  m_tlast  <= 1'b0;
                  m_tuser  <= 1'b0;
                end
                comp_first <= 1'b1;
                comp_nz    <= 1'b1;
              end else begin
                m_tdata  <= mapped;
                m_tlast  <= (pos_next == len);
                m_tuser  <= 1'b0;
                if (in_core) comp_first <= 1'b0;
              end
              sep_done <= 1'b0;
              pos      <= pos_next;
              if (pos_next == len) begin
                count    <= '0;
                overflow <= 1'b0;
                state    <= S_LOAD;
              end else begin
                state <= S_FETCH;
              end
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // a flagged result carries no character and closes its identifier
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == 8'd0)))
    else $error("too_long transfer malformed");

  // the store count never passes its capacity
  assert property (@(posedge clk) disable iff (rst) count <= LEN_W'(MAX_LEN))
    else $error("store count beyond capacity");

  // the core never starts after it ends
  assert property (@(posedge clk) disable iff (rst) info.core_b <= info.core_e)
    else $error("core bounds inverted");

  // a new emission starts from the first stored byte with a fresh component
  assert property (@(posedge clk) disable iff (rst)
    (s_xfer && s_tlast && store_wr) |=> ((pos == '0) && comp_first && (state == S_FETCH)))
    else $error("emission did not start cleanly");

endmodule

@@ tb/identifier_case_style_checker.sv @@
`timescale 1ns / 100ps
// checker for the identifier case-style converter: watches both streams and the style port,
// converts each identifier on its own and compares every output transfer; uses icsc_pkg
module identifier_case_style_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_wdata,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic       m_tlast,
  input  logic       m_tuser,
  output int         fail_count,
  output int         pending
);
  import icsc_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       long;
  } out_byte_t;

  out_byte_t  expected_bytes[$];
  logic [7:0] id_buf[MAX_LEN];
  int         id_len;
  logic       id_over;
  style_t     cur_style;

  function automatic logic [7:0] to_up(logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [7:0] to_lo(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic logic upper(logic [7:0] c);
    return c >= "A" && c <= "Z";
  endfunction

  function automatic logic sep(logic [7:0] c);
    return c == CH_US || c == CH_DS;
  endfunction

  task automatic push_byte(logic [7:0] c);
    out_byte_t r;
    r.ch = c;
    r.last = 1'b0;
    r.long = 1'b0;
    expected_bytes.push_back(r);
  endtask

  // convert the buffered identifier into expected output bytes
  task automatic convert_identifier();
    int b, e, nc, n0, pos, en, st, lc;
    int cs[MAX_LEN];
    int cl[MAX_LEN];
    logic [7:0] split;
    logic u;
    b = 0;
    e = id_len;
    nc = 0;
    split = 8'h00;
    n0 = expected_bytes.size();
    while (b < id_len && sep(id_buf[b])) b++;
    while (e > b && sep(id_buf[e-1])) e--;
    for (int i = 0; i < b; i++) push_byte(id_buf[i]);
    if (e > b) begin
      for (int i = b; i < e; i++) if (id_buf[i] == CH_US) split = CH_US;
      if (split == 8'h00) for (int i = b; i < e; i++) if (id_buf[i] == CH_DS) split = CH_DS;
      if (split != 8'h00) begin
        pos = b;
        for (int i = b; i <= e; i++) begin
          if (i == e || id_buf[i] == split) begin
            cs[nc] = pos;
            cl[nc] = i - pos;
            nc++;
            pos = i + 1;
          end
        end
      end else begin
        // camel split: a lower run, or an upper run that yields its last letter
        lc = e - b;
        st = 0;
        en = 0;
        while (1) begin
          en++;
          if (en < lc) begin
            if (!upper(id_buf[b+en])) begin
              en++;
              while (en < lc && !upper(id_buf[b+en])) en++;
            end else if (!(en == 1 && !upper(id_buf[b]))) begin
              en++;
              while (en < lc) begin
                if (id_buf[b+en] >= "a" && id_buf[b+en] <= "z") begin
                  en--;
                  break;
                end
                en++;
              end
            end
          end
          cs[nc] = b + st;
          cl[nc] = en - st;
          nc++;
          if (en >= lc) break;
          st = en;
        end
      end
      for (int k = 0; k < nc; k++) begin
        if (k != 0 && cur_style >= STY_SNAKE)
          push_byte(cur_style >= STY_KEBAB ? CH_DS : CH_US);
        for (int i = 0; i < cl[k]; i++) begin
          if (cur_style == STY_SCREAM_SNAKE || cur_style == STY_SCREAM_KEBAB) u = 1'b1;
          else if (i != 0) u = 1'b0;
          else if (cur_style == STY_CAMEL) u = (k != 0);
          else u = cur_style == STY_PASCAL || cur_style == STY_UPPER_SNAKE ||
                   cur_style == STY_UPPER_KEBAB;
          push_byte(u ? to_up(id_buf[cs[k]+i]) : to_lo(id_buf[cs[k]+i]));
        end
      end
    end
    for (int i = e; i < id_len; i++) push_byte(id_buf[i]);
    if (expected_bytes.size() > n0) expected_bytes[expected_bytes.size()-1].last = 1'b1;
  endtask

  assign pending = expected_bytes.size();

  always @(posedge clk) begin
    out_byte_t r;
    out_byte_t got;
    if (rst) begin
      id_len = 0;
      id_over = 1'b0;
      cur_style <= STY_CAMEL;
      fail_count <= 0;
    end else begin
      if (cfg_we) cur_style <= cfg_wdata;
      // input transfer: store, or convert on the last character
      if (s_tvalid && s_tready) begin
        if (id_len < MAX_LEN) begin
          id_buf[id_len] = s_tdata;
          id_len = id_len + 1;
        end else begin
          id_over = 1'b1;
        end
        if (s_tlast) begin
          if (id_over) begin
            r.ch = 8'h00;
            r.last = 1'b1;
            r.long = 1'b1;
            expected_bytes.push_back(r);
          end else begin
            convert_identifier();
          end
          id_len = 0;
          id_over = 1'b0;
        end
      end
      // output transfer against the oldest expectation
      if (m_tvalid && m_tready) begin
        got.ch = m_tdata;
        got.last = m_tlast;
        got.long = m_tuser;
        if (expected_bytes.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected output transfer: char %h last %b too_long %b",
                     got.ch, got.last, got.long);
          fail_count <= fail_count + 1;
        end else begin
          r = expected_bytes.pop_front();
          if (r != got) begin
            if (fail_count < 10)
              $display("mismatch: expected char %h last %b too_long %b, got %h %b %b",
                       r.ch, r.last, r.long, got.ch, got.last, got.long);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// testbench top for the identifier case-style converter: drives identifiers and styles,
// stalls both sides; depends on icsc_pkg, the converter rtl and identifier_case_style_checker
module tb;
  import icsc_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_wdata = 3'd0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;
  int         fail_count;
  int         pending;

  // receiver stall controls
  logic       hold_off = 1'b0;
  logic       calm = 1'b0;

  logic [7:0] word_buf[$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  identifier_case_style_converter u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  identifier_case_style_checker u_check (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser), .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stalls, none while calm, stalled throughout while held off
  always @(posedge clk) begin
    if (rst || hold_off) m_tready <= 1'b0;
    else if (calm) m_tready <= 1'b1;
    else m_tready <= ($urandom_range(99) >= 17);
  end

  // send one character, with random idle cycles first unless calm
  task automatic send_char(logic [7:0] c, logic fin);
    while (!calm && $urandom_range(99) < 17) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= c;
    s_tlast <= fin;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // send the buffered identifier, last character flagged
  task automatic send_word();
    for (int i = 0; i < word_buf.size(); i++) begin
      send_char(word_buf[i], i == word_buf.size() - 1);
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_text(string s);
    word_buf.delete();
    for (int i = 0; i < s.len(); i++) word_buf.push_back(s[i]);
    send_word();
  endtask

  // wait for all results, then let the block settle before a style write
  task automatic drain_and_set(logic [2:0] st);
    while (pending != 0) @(posedge clk);
    repeat (140) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= st;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_letter_char();
    unique case ($urandom_range(9))
      0, 1: return 8'h41 + 8'($urandom_range(25));
      2, 3, 4: return 8'h61 + 8'($urandom_range(25));
      5: return CH_US;
      6: return CH_DS;
      7: return 8'h30 + 8'($urandom_range(9));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    cfg_we <= 1'b1;
    cfg_wdata <= STY_SCREAM_KEBAB;
    @(posedge clk);
    cfg_we <= 1'b0;
    // directed: every split rule, separator runs, empty components, odd bytes
    send_text("__fooBarBAZ_--");
    send_text("a");
    send_text("HTTPServer");
    drain_and_set(STY_CAMEL);
    send_text("x__y-z");
    send_text("foo-bar");
    send_text("-_-");
    drain_and_set(STY_SNAKE);
    word_buf.delete();
    word_buf.push_back(8'hFF);
    word_buf.push_back(8'h00);
    word_buf.push_back(8'h7A);
    word_buf.push_back(8'h40);
    word_buf.push_back(8'h5B);
    word_buf.push_back(8'h60);
    word_buf.push_back(8'h7B);
    word_buf.push_back(8'h80);
    send_word();
    // too long: one over capacity, then exactly at capacity
    word_buf.delete();
    repeat (MAX_LEN + 1) word_buf.push_back(8'h41 + 8'($urandom_range(25)));
    send_word();
    word_buf.delete();
    repeat (MAX_LEN) word_buf.push_back(8'h61);
    send_word();
    // random identifiers under randomly chosen styles
    for (int w = 0; w < 16; w++) begin
      if (w % 4 == 0) drain_and_set(3'($urandom_range(7)));
      calm = (w >= 4 && w < 8);
      if (w == 10) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk);
            hold_off = 1'b0;
          end
        join_none
      end
      if (w == 13) while (pending != 0) @(posedge clk);
      word_buf.delete();
      n = 1 + int'($urandom_range(6));
      repeat (n) word_buf.push_back(rand_letter_char());
      send_word();
    end
    calm = 1'b0;
    drain_and_set(STY_PASCAL);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/icsc_pkg.sv
rtl/icsc_ram.sv
rtl/icsc_scan.sv
rtl/identifier_case_style_converter.sv
tb/identifier_case_style_checker.sv
tb/tb.sv
